/* sv/haversine_path_distance_top_assert.svh */
// Assertion macros used by the haversine path distance RTL.
`ifndef HAVERSINE_PATH_DISTANCE_TOP_ASSERT_SVH
`define HAVERSINE_PATH_DISTANCE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hpd_pkg.sv */
// Package: constants, tables, command and status types for the path distance block.
package hpd_pkg;

  localparam int HPD_CORDIC_STEPS = 24;
  localparam int HPD_TOTAL_BITS   = 48;
  localparam int HPD_FRAC         = 40;
  localparam int ARC_MAX          = 40;
  localparam int ARC_IDX_W        = $clog2(ARC_MAX);

  localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
  localparam logic [63:0] RAD_PER_UNIT = PI_Q60 / 64'd450000000;
  localparam logic [33:0] FULL_CIRCLE  = 34'd3600000000;
  localparam logic [33:0] HALF_CIRCLE  = 34'd1800000000;
  localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;

  localparam logic [22:0] RADIUS_RESET = 23'd6371000;
  localparam int CFG_ADDR_W = 2;

  // multiply operand selects
  localparam logic [2:0] MS_RAD  = 3'd0;
  localparam logic [2:0] MS_S1S1 = 3'd1;
  localparam logic [2:0] MS_T0P  = 3'd2;
  localparam logic [2:0] MS_C1C2 = 3'd3;
  localparam logic [2:0] MS_S2S2 = 3'd4;
  localparam logic [2:0] MS_T0T1 = 3'd5;
  localparam logic [2:0] MS_SEG  = 3'd6;

  typedef logic [63:0] arc_tab_t [0:ARC_MAX-1];

  typedef struct packed {
    logic       ld_in;
    logic       mul_start;
    logic [2:0] mul_sel;
    logic       mul_store;
    logic       rot_start;
    logic       vec_start;
    logic [1:0] ang_idx;
    logic       ang_store;
    logic       clamp;
    logic       sq_start;
    logic       sq_sel;
    logic       sq_store;
    logic       total_upd;
    logic       out_load;
  } hpd_cmd_t;

  typedef struct packed {
    logic need;
    logic mul_done;
    logic cor_done;
    logic sq_done;
    logic u_zero;
    logic out_free;
  } hpd_sts_t;

  // atan(2^-i) in Q40, from the Taylor series in Q62
  function automatic arc_tab_t hpd_build_arcs();
    arc_tab_t    t;
    logic [63:0] acc;
    logic [63:0] term;
    for (int i = 0; i < ARC_MAX; i++) begin
      acc = (i == 0) ? PI_Q60 : 64'd0;
      if (i > 0) begin
        for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
          term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
          acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
      end
      t[i] = (acc + (64'd1 << 21)) >> 22;
    end
    return t;
  endfunction

  localparam arc_tab_t ARC = hpd_build_arcs();

  function automatic logic [63:0] hpd_gain(int steps);
    logic [63:0] p;
    p = 64'd1 << HPD_FRAC;
    for (int i = 0; i < steps; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    return p;
  endfunction

  function automatic logic [63:0] hpd_gain_sq(int steps);
    logic [127:0] w;
    w = 128'(hpd_gain(steps)) * 128'(hpd_gain(steps));
    return w[103:40];
  endfunction

endpackage

/* sv/haversine_path_distance_top.sv */
// Top level: waypoint in, segment and running total out, radius register.
//
//  channel | dir | carries
//  in_     | in  | one waypoint request (latitude, longitude, flags)
//  out_    | out | one result per waypoint (segment, total, saturation)
//  cfg_    | in  | earth radius register write/read
//
// A path start goes from acceptance through the prepare, finish and output states
// back to ready. A measured segment's time is set by the shared CORDIC unit,
// the multiplier and the square root, all used in turn. One waypoint is in
// flight at a time; a finished result waits in the output register while the
// next is taken. Reset is synchronous, clears the stored point and total,
// restores the radius.
module haversine_path_distance_top
  import hpd_pkg::*;
#(
  parameter int CORDIC_STEPS = HPD_CORDIC_STEPS,
  parameter int TOTAL_BITS   = HPD_TOTAL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,    // latitude, longitude, zero pad
  input  logic [1:0]            in_tuser,    // path_start, clear_total
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [87:0]           out_tdata,   // segment_mm, total_mm, zero pad
  output logic [0:0]            out_tuser,   // total_saturated
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [22:0] radius_r;
  hpd_cmd_t    cmd;
  hpd_sts_t    sts;
  logic [34:0] seg;
  logic [47:0] tot;
  logic        sat;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == '0) ? 32'(radius_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      radius_r <= cfg_pwdata[22:0];
    end
  end

  hpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hpd_dp #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .TOTAL_BITS   (TOTAL_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .latitude        ($signed(in_tdata[30:0])),
    .longitude       ($signed(in_tdata[62:31])),
    .path_start      (in_tuser[0]),
    .clear_total     (in_tuser[1]),
    .radius          (radius_r),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .segment_mm      (seg),
    .total_mm        (tot),
    .total_saturated (sat)
  );

  assign out_tdata = {5'd0, tot, seg};
  assign out_tuser = sat;

endmodule

/* sv/hpd_mul.sv */
// 64x64 multiplier built from one 32x32 product, taking the four partial products in turn.
module hpd_mul
  import hpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         busy,
  output logic         done
);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   step_r;
  logic         busy_r, done_r;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [1:0]   quad;

  always_comb begin
    pa      = step_r[0] ? a_r[63:32] : a_r[31:0];
    pb      = step_r[1] ? b_r[63:32] : b_r[31:0];
    pp      = 64'(pa) * 64'(pb);
    quad    = 2'(step_r[0]) + 2'(step_r[1]);
    acc_nxt = acc_r + (128'(pp) << {quad, 5'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign prod = acc_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

/* sv/hpd_cordic.sv */
// Shared CORDIC unit, rotation or vectoring, one iteration per cycle.
module hpd_cordic
  import hpd_pkg::*;
#(
  parameter int CORDIC_STEPS = HPD_CORDIC_STEPS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        vec,
  input  logic [63:0] x0,
  input  logic [63:0] y0,
  input  logic [63:0] z0,
  output logic [63:0] x,
  output logic [63:0] y,
  output logic [63:0] z,
  output logic        busy,
  output logic        done
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic [63:0]   x_r, y_r, z_r;
  logic [IW-1:0] i_r;
  logic          vec_r, busy_r, done_r;
  logic [63:0]   xs, ys, arc;
  logic          pos;

  always_comb begin
    xs  = 64'($signed(x_r) >>> i_r);
    ys  = 64'($signed(y_r) >>> i_r);
    arc = ARC[ARC_IDX_W'(i_r)];
    pos = vec_r ? y_r[63] : !z_r[63];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + IW'(1);
        if (i_r == IW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
      vec_r <= vec;
    end else if (busy_r) begin
      if (pos) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - arc;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + arc;
      end
    end
  end

  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

/* sv/hpd_dp.sv */
// Datapath: waypoint state, angle prep, products, square roots, total and result register.
module hpd_dp
  import hpd_pkg::*;
#(
  parameter int CORDIC_STEPS = HPD_CORDIC_STEPS,
  parameter int TOTAL_BITS   = HPD_TOTAL_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hpd_cmd_t          cmd,
  output hpd_sts_t          sts,
  input  logic signed [30:0] latitude,
  input  logic signed [31:0] longitude,
  input  logic              path_start,
  input  logic              clear_total,
  input  logic [22:0]       radius,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [34:0]       segment_mm,
  output logic [47:0]       total_mm,
  output logic              total_saturated
);

  localparam logic [63:0] GAIN    = hpd_gain(CORDIC_STEPS);
  localparam logic [63:0] GAIN_SQ = hpd_gain_sq(CORDIC_STEPS);
  localparam logic [TOTAL_BITS-1:0] LIMIT = '1;

  logic signed [30:0] prev_lat_r;
  logic signed [31:0] prev_lon_r;
  logic               have_prev_r, need_r;
  logic [30:0]        ang_r [0:3];
  logic [63:0]        s1_r, s2_r, c1_r, c2_r, t0_r, t1_r, n_r, d_r, u_r, v_r, seg_r;
  logic [TOTAL_BITS-1:0] total_r;
  logic               out_valid_r, out_sat_r;
  logic [34:0]        out_seg_r;
  logic [47:0]        out_tot_r;

  logic signed [30:0] lat_sat;
  logic signed [31:0] dlat_s;
  logic signed [33:0] dlon_a, dlon_b, dlon_c;
  logic [30:0]        dlat_u, dlon_u, plat2, clat2;

  logic [127:0] mprod;
  logic         mbusy, mdone;
  logic [63:0]  ma, mb, mq, rad;
  logic [63:0]  cx, cy, cz, cx0, cy0, cz0;
  logic         cbusy, cdone;
  logic [63:0]  r1000, zpos, ncl;

  logic [63:0]  sq_num_r, sq_res_r, sq_bit_r, sq_try;
  logic [4:0]   sq_cnt_r;
  logic         sq_busy_r, sq_done_r;

  logic [63:0]  tot_ext;

  // input preparation
  always_comb begin
    if (latitude > LAT_LIMIT)       lat_sat = LAT_LIMIT;
    else if (latitude < -LAT_LIMIT) lat_sat = -LAT_LIMIT;
    else                            lat_sat = latitude;
    dlat_s = 32'(lat_sat) - 32'(prev_lat_r);
    dlat_u = dlat_s[31] ? 31'(-dlat_s) : 31'(dlat_s);
    dlon_a = 34'(longitude) - 34'(prev_lon_r);
    if (dlon_a >= $signed(FULL_CIRCLE))       dlon_b = dlon_a - $signed(FULL_CIRCLE);
    else if (dlon_a <= -$signed(FULL_CIRCLE)) dlon_b = dlon_a + $signed(FULL_CIRCLE);
    else                                      dlon_b = dlon_a;
    dlon_c = dlon_b[33] ? dlon_b + $signed(FULL_CIRCLE) : dlon_b;
    dlon_u = (dlon_c > $signed(HALF_CIRCLE)) ? 31'($signed(FULL_CIRCLE) - dlon_c)
                                             : 31'(dlon_c);
    plat2  = prev_lat_r[30] ? 31'(-32'(prev_lat_r)) << 1 : 31'(prev_lat_r) << 1;
    clat2  = lat_sat[30] ? 31'(-32'(lat_sat)) << 1 : 31'(lat_sat) << 1;
  end

  // multiply and CORDIC operands
  always_comb begin
    mq    = mprod[103:40];
    rad   = (mprod[63:0] + (64'd1 << 22)) >> 23;
    r1000 = (64'(radius) << 10) - (64'(radius) << 4) - (64'(radius) << 3);
    zpos  = cz[63] ? 64'd0 : cz << 1;
    ncl   = (n_r > GAIN_SQ) ? GAIN_SQ : n_r;
    ma    = '0;
    mb    = '0;
    case (cmd.mul_sel)
      MS_RAD:  begin ma = 64'(ang_r[cmd.ang_idx]); mb = RAD_PER_UNIT; end
      MS_S1S1: begin ma = s1_r; mb = s1_r; end
      MS_T0P:  begin ma = t0_r; mb = GAIN; end
      MS_C1C2: begin ma = c1_r; mb = c2_r; end
      MS_S2S2: begin ma = s2_r; mb = s2_r; end
      MS_T0T1: begin ma = t0_r; mb = t1_r; end
      MS_SEG:  begin ma = r1000; mb = zpos; end
      default: begin ma = '0; mb = '0; end
    endcase
    cx0 = cmd.vec_start ? v_r << 10 : 64'd1 << HPD_FRAC;
    cy0 = cmd.vec_start ? u_r << 10 : 64'd0;
    cz0 = cmd.vec_start ? 64'd0 : rad;
  end

  hpd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (ma),
    .b     (mb),
    .prod  (mprod),
    .busy  (mbusy),
    .done  (mdone)
  );

  hpd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.rot_start | cmd.vec_start),
    .vec   (cmd.vec_start),
    .x0    (cx0),
    .y0    (cy0),
    .z0    (cz0),
    .x     (cx),
    .y     (cy),
    .z     (cz),
    .busy  (cbusy),
    .done  (cdone)
  );

  // restoring square root, one result bit per cycle
  assign sq_try = sq_res_r + sq_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_done_r <= 1'b0;
      sq_cnt_r  <= '0;
    end else begin
      sq_done_r <= 1'b0;
      if (cmd.sq_start) begin
        sq_busy_r <= 1'b1;
        sq_cnt_r  <= '0;
      end else if (sq_busy_r) begin
        sq_cnt_r <= sq_cnt_r + 5'd1;
        if (sq_cnt_r == 5'd31) begin
          sq_busy_r <= 1'b0;
          sq_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      sq_num_r <= (cmd.sq_sel ? d_r : n_r) << 20;
      sq_res_r <= '0;
      sq_bit_r <= 64'd1 << 62;
    end else if (sq_busy_r) begin
      if (sq_num_r >= sq_try) begin
        sq_num_r <= sq_num_r - sq_try;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  // waypoint state and running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_lat_r  <= '0;
      prev_lon_r  <= '0;
      have_prev_r <= 1'b0;
      need_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ld_in) begin
        prev_lat_r  <= lat_sat;
        prev_lon_r  <= longitude;
        have_prev_r <= 1'b1;
        need_r      <= have_prev_r && !path_start;
        if (clear_total) total_r <= '0;
      end
      if (cmd.total_upd) begin
        if (seg_r > 64'(LIMIT - total_r)) total_r <= LIMIT;
        else                              total_r <= total_r + TOTAL_BITS'(seg_r);
      end
      if (cmd.out_load)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      ang_r[0] <= dlat_u;
      ang_r[1] <= dlon_u;
      ang_r[2] <= plat2;
      ang_r[3] <= clat2;
      seg_r    <= '0;
    end
    if (cmd.ang_store) begin
      case (cmd.ang_idx)
        2'd0:    s1_r <= cy[63] ? 64'd0 : cy;
        2'd1:    s2_r <= cy[63] ? 64'd0 : cy;
        2'd2:    c1_r <= cx[63] ? 64'd0 : cx;
        default: c2_r <= cx[63] ? 64'd0 : cx;
      endcase
    end
    if (cmd.mul_store) begin
      case (cmd.mul_sel)
        MS_S1S1: t0_r  <= mq;
        MS_T0P:  n_r   <= mq;
        MS_C1C2: t0_r  <= mq;
        MS_S2S2: t1_r  <= mq;
        MS_T0T1: n_r   <= n_r + mq;
        MS_SEG:  seg_r <= mq;
        default: ;
      endcase
    end
    if (cmd.clamp) begin
      n_r <= ncl;
      d_r <= GAIN_SQ - ncl;
    end
    if (cmd.sq_store) begin
      if (cmd.sq_sel) v_r <= sq_res_r;
      else            u_r <= sq_res_r;
    end
  end

  assign tot_ext = 64'(total_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_seg_r <= seg_r[34:0];
      out_tot_r <= tot_ext[47:0];
      out_sat_r <= (total_r == LIMIT);
    end
  end

  always_comb begin
    sts.need     = need_r;
    sts.mul_done = mdone;
    sts.cor_done = cdone;
    sts.sq_done  = sq_done_r;
    sts.u_zero   = (u_r == 64'd0);
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign segment_mm      = out_seg_r;
  assign total_mm        = out_tot_r;
  assign total_saturated = out_sat_r;

`include "haversine_path_distance_top_assert.svh"

  `HPD_ASSERT_IMP(a_out_no_overwrite, cmd.out_load, !out_valid_r || out_ready, "result overwritten")
  `HPD_ASSERT_IMP(a_mul_idle, cmd.mul_start, !mbusy, "multiply started while busy")
  `HPD_ASSERT_IMP(a_cordic_idle, cmd.rot_start || cmd.vec_start, !cbusy, "cordic started while busy")
  `HPD_ASSERT_NXT(a_total_grows, cmd.total_upd, total_r >= $past(total_r), "total wrapped")

endmodule

/* sv/hpd_ctrl.sv */
// Controller: sequences angle, product, root and distance steps for one waypoint.
module hpd_ctrl
  import hpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hpd_sts_t sts,
  output hpd_cmd_t cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PREP   = 5'd1;
  localparam logic [4:0] S_A_MUL  = 5'd2;
  localparam logic [4:0] S_A_MULW = 5'd3;
  localparam logic [4:0] S_A_ROT  = 5'd4;
  localparam logic [4:0] S_A_ROTW = 5'd5;
  localparam logic [4:0] S_P_MUL  = 5'd6;
  localparam logic [4:0] S_P_MULW = 5'd7;
  localparam logic [4:0] S_CLAMP  = 5'd8;
  localparam logic [4:0] S_SQ     = 5'd9;
  localparam logic [4:0] S_SQW    = 5'd10;
  localparam logic [4:0] S_V      = 5'd11;
  localparam logic [4:0] S_VW     = 5'd12;
  localparam logic [4:0] S_S_MUL  = 5'd13;
  localparam logic [4:0] S_S_MULW = 5'd14;
  localparam logic [4:0] S_FIN    = 5'd15;
  localparam logic [4:0] S_OUT    = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] psel;

  always_comb begin
    case (cnt_r)
      3'd0:    psel = MS_S1S1;
      3'd1:    psel = MS_T0P;
      3'd2:    psel = MS_C1C2;
      3'd3:    psel = MS_S2S2;
      default: psel = MS_T0T1;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.ang_idx = cnt_r[1:0];
    cmd.sq_sel  = cnt_r[0];
    in_ready    = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.ld_in = in_valid;
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        cnt_nxt   = '0;
        state_nxt = sts.need ? S_A_MUL : S_FIN;
      end
      S_A_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_RAD;
        state_nxt     = S_A_MULW;
      end
      S_A_MULW: begin
        cmd.mul_sel = MS_RAD;
        if (sts.mul_done) state_nxt = S_A_ROT;
      end
      S_A_ROT: begin
        cmd.rot_start = 1'b1;
        state_nxt     = S_A_ROTW;
      end
      S_A_ROTW: begin
        cmd.ang_store = sts.cor_done;
        if (sts.cor_done) begin
          if (cnt_r == 3'd3) begin
            cnt_nxt   = '0;
            state_nxt = S_P_MUL;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            state_nxt = S_A_MUL;
          end
        end
      end
      S_P_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = psel;
        state_nxt     = S_P_MULW;
      end
      S_P_MULW: begin
        cmd.mul_sel   = psel;
        cmd.mul_store = sts.mul_done;
        if (sts.mul_done) begin
          if (cnt_r == 3'd4) begin
            cnt_nxt   = '0;
            state_nxt = S_CLAMP;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            state_nxt = S_P_MUL;
          end
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq_start = 1'b1;
        state_nxt    = S_SQW;
      end
      S_SQW: begin
        cmd.sq_store = sts.sq_done;
        if (sts.sq_done) begin
          if (cnt_r[0]) state_nxt = S_V;
          else begin
            cnt_nxt   = 3'd1;
            state_nxt = S_SQ;
          end
        end
      end
      S_V: begin
        if (sts.u_zero) state_nxt = S_FIN;
        else begin
          cmd.vec_start = 1'b1;
          state_nxt     = S_VW;
        end
      end
      S_VW: begin
        if (sts.cor_done) state_nxt = S_S_MUL;
      end
      S_S_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_SEG;
        state_nxt     = S_S_MULW;
      end
      S_S_MULW: begin
        cmd.mul_sel   = MS_SEG;
        cmd.mul_store = sts.mul_done;
        if (sts.mul_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.total_upd = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
